// File: src/gdt_pkg.sv
// Package for the text grid core: grid geometry, request codes, sequencer
// states and the cell memory request bundle. No dependencies.
package gdt_pkg;

	localparam int ROWS_MAX = 8;
	localparam int COLUMNS  = 16;
	localparam int ROW_W    = $clog2(ROWS_MAX);
	localparam int COL_W    = $clog2(COLUMNS);
	localparam int ADDR_W   = ROW_W + COL_W;
	localparam int CELLS    = ROWS_MAX * COLUMNS;
	localparam int CODE_W   = 16;
	localparam int RIU_W    = 4;
	localparam int SLOT_W   = 3;

	localparam logic [CODE_W-1:0] SPACE_CODE   = CODE_W'(16'h0020);
	localparam logic [7:0]        CUSTOM_LIMIT = 8'd8;

	typedef enum logic [3:0] {
		REQ_CLEAR           = 4'd0,
		REQ_SET_CURSOR      = 4'd1,
		REQ_NEWLINE         = 4'd2,
		REQ_WRITE_CP        = 4'd3,
		REQ_WRITE_BYTE      = 4'd4,
		REQ_READ_CELL       = 4'd5,
		REQ_MARK_CELL       = 4'd6,
		REQ_MARK_ALL        = 4'd7,
		REQ_MARK_SLOT       = 4'd8,
		REQ_READ_DIRTY      = 4'd9,
		REQ_CLEAR_DIRTY_ROW = 4'd10,
		REQ_CLEAR_COLUMNS   = 4'd11,
		REQ_ANY_DIRTY       = 4'd12
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN_RD,
		ST_SCAN_CMP
	} st_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [CODE_W-1:0] wr_data;
		logic              clr;
	} mem_req_t;

endpackage

// File: src/gdt_cell_mem.sv
// Cell code store: single-port-write, registered-read memory of all grid cells.
// Per-cell valid bits give the space code for cells not written since clear.
// Depends on gdt_pkg.
module gdt_cell_mem (
	input  logic                     clk,
	input  logic                     arst_n,
	input  gdt_pkg::mem_req_t        mem_req,
	output logic [gdt_pkg::CODE_W-1:0] rd_code
);
	import gdt_pkg::*;

	logic [CODE_W-1:0] mem_q [CELLS];
	logic [CELLS-1:0]  valid_q;
	logic [CODE_W-1:0] rd_data_q;
	logic              rd_valid_q;

	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			mem_q[mem_req.wr_addr] <= mem_req.wr_data;
		end
		if (mem_req.rd_en) begin
			rd_data_q <= mem_q[mem_req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (mem_req.clr) begin
				valid_q <= '0;
			end else if (mem_req.wr_en) begin
				valid_q[mem_req.wr_addr] <= 1'b1;
			end
			if (mem_req.rd_en) begin
				rd_valid_q <= valid_q[mem_req.rd_addr];
			end
		end
	end

	assign rd_code = rd_valid_q ? rd_data_q : SPACE_CODE;

endmodule

// File: src/gdt_cmp_unit.sv
// Shared cell compare: matches a stored code and custom flag against an operand.
// Used for write change detection and for the custom slot scan. Depends on gdt_pkg.
module gdt_cmp_unit (
	input  logic [gdt_pkg::CODE_W-1:0] stored_code,
	input  logic                       stored_custom,
	input  logic [gdt_pkg::CODE_W-1:0] op_code,
	input  logic                       op_custom,
	output logic                       match
);
	import gdt_pkg::*;

	assign match = (stored_code == op_code) && (stored_custom == op_custom);

endmodule

// File: src/text_grid_with_dirty_tracking_core.sv
// Text grid core with per-cell dirty tracking and an auto-advancing cursor.
// Ordering: an accepted request goes to the exec state and loads the result register once the
// output is free; mark_slot first walks the active rows cell by cell through the cell memory
// read port, with a read state and then a compare state per cell. One request at a time; in_stall
// stays high until its result is loaded, so no new request is taken before then.
// Reset is immediate: cell valid bits, flags and cursor clear while arst_n is low.
module text_grid_with_dirty_tracking_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  rows_in_use,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  req_type,
	input  logic [3:0]  x_col,
	input  logic [2:0]  y_row,
	input  logic [15:0] char_value,
	input  logic [2:0]  slot_number,
	input  logic [15:0] column_mask,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        changed,
	output logic [15:0] cell_code,
	output logic        cell_custom,
	output logic [15:0] row_dirty_bits,
	output logic        dirty_pending,
	output logic        slot_found
);
	import gdt_pkg::*;

	st_t st_q, st_d;

	logic [3:0]        req_q;
	logic [COL_W-1:0]  x_q;
	logic [ROW_W-1:0]  y_q;
	logic [CODE_W-1:0] val_q;
	logic [SLOT_W-1:0] slot_q;
	logic [COLUMNS-1:0] cmask_q;

	logic [RIU_W-1:0]  riu_q;
	logic [COL_W-1:0]  cur_col_q, cur_col_d;
	logic [ROW_W-1:0]  cur_row_q, cur_row_d;
	logic [COLUMNS-1:0] custom_q [ROWS_MAX];
	logic [COLUMNS-1:0] custom_d [ROWS_MAX];
	logic [COLUMNS-1:0] dirty_q  [ROWS_MAX];
	logic [COLUMNS-1:0] dirty_d  [ROWS_MAX];
	logic [ADDR_W-1:0] scan_q, scan_d;
	logic              found_q, found_d;

	logic              out_valid_q;
	logic              changed_q, cell_custom_q, dirty_pending_q, slot_found_q;
	logic [CODE_W-1:0] cell_code_q;
	logic [COLUMNS-1:0] row_dirty_q;

	// sequencer outputs
	logic     in_accept, out_free, exec_go, scan_cmp, scan_last;
	mem_req_t mem_req;

	// datapath
	logic [CODE_W-1:0] rd_code;
	logic [CODE_W-1:0] op_code;
	logic              op_custom, stored_custom, match;
	logic              is_write, y_active, cur_active;
	logic [CODE_W-1:0] new_code;
	logic              new_custom, wr_changed;
	logic [ROW_W-1:0]  scan_row;
	logic [COL_W-1:0]  scan_col;
	logic [ROW_W-1:0]  last_row;
	logic              any_dirty_d;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			riu_q <= RIU_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			if (rows_in_use == '0) begin
				riu_q <= RIU_W'(1);
			end else if (rows_in_use > RIU_W'(ROWS_MAX)) begin
				riu_q <= RIU_W'(ROWS_MAX);
			end else begin
				riu_q <= rows_in_use;
			end
		end
	end

	// ---------------- sequencer ----------------
	assign scan_row  = scan_q[ADDR_W-1:COL_W];
	assign scan_col  = scan_q[COL_W-1:0];
	assign last_row  = ROW_W'(riu_q - RIU_W'(1));
	assign scan_last = (scan_row == last_row) && (scan_col == COL_W'(COLUMNS - 1));
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					st_d = (req_type == REQ_MARK_SLOT) ? ST_SCAN_RD : ST_EXEC;
				end
			end
			ST_SCAN_RD:  st_d = ST_SCAN_CMP;
			ST_SCAN_CMP: st_d = scan_last ? ST_EXEC : ST_SCAN_RD;
			ST_EXEC: begin
				if (out_free) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_accept = 1'b0;
		exec_go   = 1'b0;
		scan_cmp  = 1'b0;
		in_stall  = 1'b1;
		case (st_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				in_accept = in_valid;
			end
			ST_EXEC:     exec_go  = out_free;
			ST_SCAN_CMP: scan_cmp = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// request word latch
	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_q   <= req_type;
			x_q     <= x_col[COL_W-1:0];
			y_q     <= y_row[ROW_W-1:0];
			val_q   <= char_value;
			slot_q  <= slot_number;
			cmask_q <= column_mask[COLUMNS-1:0];
		end
	end

	// ---------------- cell memory and compare unit ----------------
	assign is_write   = (req_q == REQ_WRITE_CP) || (req_q == REQ_WRITE_BYTE);
	assign new_code   = (req_q == REQ_WRITE_BYTE) ? CODE_W'(val_q[7:0]) : val_q;
	assign new_custom = (req_q == REQ_WRITE_BYTE) && (val_q[7:0] < CUSTOM_LIMIT);

	always_comb begin
		if (scan_cmp) begin
			op_code       = CODE_W'(slot_q);
			op_custom     = 1'b1;
			stored_custom = custom_q[scan_row][scan_col];
		end else begin
			op_code       = new_code;
			op_custom     = new_custom;
			stored_custom = custom_q[cur_row_q][cur_col_q];
		end
	end

	gdt_cmp_unit u_cmp (
		.stored_code   (rd_code),
		.stored_custom (stored_custom),
		.op_code       (op_code),
		.op_custom     (op_custom),
		.match         (match)
	);

	assign wr_changed = !match;

	always_comb begin
		mem_req.rd_en   = in_accept || (st_q == ST_SCAN_RD);
		if (st_q == ST_SCAN_RD) begin
			mem_req.rd_addr = scan_q;
		end else if (req_type == REQ_READ_CELL) begin
			mem_req.rd_addr = {y_row[ROW_W-1:0], x_col[COL_W-1:0]};
		end else begin
			mem_req.rd_addr = {cur_row_q, cur_col_q};
		end
		mem_req.wr_en   = exec_go && is_write && wr_changed;
		mem_req.wr_addr = {cur_row_q, cur_col_q};
		mem_req.wr_data = new_code;
		mem_req.clr     = exec_go && (req_q == REQ_CLEAR);
	end

	gdt_cell_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.mem_req (mem_req),
		.rd_code (rd_code)
	);

	// ---------------- flags and cursor ----------------
	assign y_active   = RIU_W'(y_q) < riu_q;
	assign cur_active = RIU_W'(cur_row_q) < riu_q;

	always_comb begin
		cur_col_d = cur_col_q;
		cur_row_d = cur_row_q;
		scan_d    = scan_q;
		found_d   = found_q;
		for (int r = 0; r < ROWS_MAX; r++) begin
			custom_d[r] = custom_q[r];
			dirty_d[r]  = dirty_q[r];
		end

		if (in_accept) begin
			scan_d  = '0;
			found_d = 1'b0;
		end

		if (scan_cmp) begin
			scan_d = scan_q + ADDR_W'(1);
			if (match) begin
				dirty_d[scan_row][scan_col] = 1'b1;
				found_d = 1'b1;
			end
		end

		if (exec_go) begin
			case (req_q)
				REQ_CLEAR: begin
					cur_col_d = '0;
					cur_row_d = '0;
					for (int r = 0; r < ROWS_MAX; r++) begin
						custom_d[r] = '0;
						dirty_d[r]  = '0;
					end
				end
				REQ_SET_CURSOR: begin
					cur_col_d = x_q;
					cur_row_d = y_active ? y_q : last_row;
				end
				REQ_NEWLINE: begin
					cur_col_d = '0;
					if (RIU_W'(cur_row_q) + RIU_W'(1) < riu_q) begin
						cur_row_d = cur_row_q + ROW_W'(1);
					end
				end
				REQ_WRITE_CP, REQ_WRITE_BYTE: begin
					if (wr_changed) begin
						custom_d[cur_row_q][cur_col_q] = new_custom;
						if (cur_active) begin
							dirty_d[cur_row_q][cur_col_q] = 1'b1;
						end
					end
					if ((COL_W + 1)'(cur_col_q) + (COL_W + 1)'(1) < (COL_W + 1)'(COLUMNS)) begin
						cur_col_d = cur_col_q + COL_W'(1);
					end else begin
						cur_col_d = '0;
						if (RIU_W'(cur_row_q) + RIU_W'(1) < riu_q) begin
							cur_row_d = cur_row_q + ROW_W'(1);
						end
					end
				end
				REQ_MARK_CELL: begin
					if (y_active) begin
						dirty_d[y_q][x_q] = 1'b1;
					end
				end
				REQ_MARK_ALL: begin
					for (int r = 0; r < ROWS_MAX; r++) begin
						if (RIU_W'(r) < riu_q) begin
							dirty_d[r] = '1;
						end
					end
				end
				REQ_CLEAR_DIRTY_ROW: begin
					if (y_active) begin
						dirty_d[y_q] = '0;
					end
				end
				REQ_CLEAR_COLUMNS: begin
					for (int r = 0; r < ROWS_MAX; r++) begin
						if (RIU_W'(r) < riu_q) begin
							dirty_d[r] = dirty_q[r] & ~cmask_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		any_dirty_d = 1'b0;
		for (int r = 0; r < ROWS_MAX; r++) begin
			if (RIU_W'(r) < riu_q && dirty_d[r] != '0) begin
				any_dirty_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
			scan_q    <= '0;
			found_q   <= 1'b0;
			for (int r = 0; r < ROWS_MAX; r++) begin
				custom_q[r] <= '0;
				dirty_q[r]  <= '0;
			end
		end else begin
			cur_col_q <= cur_col_d;
			cur_row_q <= cur_row_d;
			scan_q    <= scan_d;
			found_q   <= found_d;
			for (int r = 0; r < ROWS_MAX; r++) begin
				custom_q[r] <= custom_d[r];
				dirty_q[r]  <= dirty_d[r];
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			changed_q       <= is_write && wr_changed;
			cell_code_q     <= '0;
			cell_custom_q   <= 1'b0;
			row_dirty_q     <= '0;
			dirty_pending_q <= any_dirty_d;
			slot_found_q    <= (req_q == REQ_MARK_SLOT) && found_q;
			if (req_q == REQ_READ_CELL) begin
				cell_code_q   <= y_active ? rd_code : SPACE_CODE;
				cell_custom_q <= y_active && custom_q[y_q][x_q];
			end
			if (req_q == REQ_READ_DIRTY && y_active) begin
				row_dirty_q <= dirty_q[y_q];
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign changed        = changed_q;
	assign cell_code      = cell_code_q;
	assign cell_custom    = cell_custom_q;
	assign row_dirty_bits = 16'(row_dirty_q);
	assign dirty_pending  = dirty_pending_q;
	assign slot_found     = slot_found_q;

endmodule

// File: src/gdt_checker.sv
// Port-level checks for the text grid core, bound to the top level.
// Sees only the top-level ports.
module gdt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        changed,
	input logic [15:0] cell_code,
	input logic        cell_custom,
	input logic [15:0] row_dirty_bits,
	input logic        dirty_pending,
	input logic        slot_found
);

	// a result word waiting on stall stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// one request at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while previous one in progress");

	// a slot hit marks an active cell dirty
	a_slot_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && slot_found |-> dirty_pending && !changed)
		else $error("slot found without pending dirty bits");

	// a nonzero row mask comes from an active row
	a_row_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && row_dirty_bits != 16'h0000 |-> dirty_pending)
		else $error("dirty row read but nothing pending");

	// a custom cell holds a slot number
	a_custom_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cell_custom |-> cell_code[15:3] == 13'h0000)
		else $error("custom cell holds a code past the slot range");

endmodule

bind text_grid_with_dirty_tracking_core gdt_checker u_gdt_checker (.*);
